// ===== design/sparse_column_group_qc_counter_core_defines.svh =====
// Assertion macros for the sparse column group QC counter.
`ifndef SPARSE_COLUMN_GROUP_QC_COUNTER_CORE_DEFINES_SVH
`define SPARSE_COLUMN_GROUP_QC_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SCGQC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCGQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCGQC_ASSERT_IMP(lbl, ante, cons, msg)
`define SCGQC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/scgqc_pkg.sv =====
// Shared types, constants and helpers of the sparse column group QC counter.
package scgqc_pkg;

  localparam int unsigned CELLS     = 4096;
  localparam int unsigned MAP_AW    = $clog2(CELLS);
  localparam int unsigned IDX_W     = 12;
  // compare width wide enough for any CELLS in range
  localparam int unsigned CMP_W     = 21;

  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned PAIRS_W   = 16;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4096;
  localparam logic [PAIRS_W-1:0] PAIRS_MAX = 16'hFFFF;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PAIRS_W-1:0] pairs_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_MARK     = 3'd1,
    CMD_MEMBER   = 3'd2,
    CMD_END_NT   = 3'd3,
    CMD_END_PAIR = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRT_THRESHOLD   = 2'd0,
    REG_CNTRL_THRESHOLD = 2'd1,
    REG_COMPLEMENT_MODE = 2'd2,
    REG_PAIRS_ENABLE    = 2'd3
  } cfg_reg_t;

  function automatic count_t count_add(input count_t a, input count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== design/scgqc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scgqc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sparse_column_group_qc_counter_core.sv =====
// Sparse column group QC counter: takes one command beat per clock cycle when
// the result side keeps up and no clearing pass runs; a beat's result (END_NT,
// or END_PAIR with pairs enabled) passes through the item stage, which holds
// the bitmap read, and then the result register that drives the out_ ports.
// The nonzero bitmap is a CELLS-deep RAM that stores an 8-bit column tag per
// cell instead of a bit, so START clears it by bumping the tag.
// After reset, and again on every 255th START after that, a clearing pass
// writes all CELLS entries while in_stall is held high; configuration writes
// are taken throughout.
`include "sparse_column_group_qc_counter_core_defines.svh"

module sparse_column_group_qc_counter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [scgqc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scgqc_pkg::COUNT_W-1:0]         cfg_wdata,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            in_cmd,
  input  logic [scgqc_pkg::IDX_W-1:0]           in_cell_index,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_kind,
  output logic [scgqc_pkg::COUNT_W-1:0]         out_trt_count,
  output logic [scgqc_pkg::COUNT_W-1:0]         out_cntrl_count,
  output logic                                  out_pair_ok,
  output logic [scgqc_pkg::COUNT_W-1:0]         out_column_total,
  output logic [scgqc_pkg::PAIRS_W-1:0]         out_ok_pairs_total
);

  // configuration registers
  scgqc_pkg::count_t trt_thr_r;
  scgqc_pkg::count_t cntrl_thr_r;
  logic              compl_mode_r;
  logic              pairs_en_r;

  // column state
  scgqc_pkg::count_t group_hits_r, group_hits_nxt;
  scgqc_pkg::count_t control_sum_r, control_sum_nxt;
  scgqc_pkg::count_t mark_count_r, mark_count_nxt;
  scgqc_pkg::pairs_t pass_pairs_r, pass_pairs_nxt;
  scgqc_pkg::epoch_t epoch_r, epoch_nxt;

  // clearing pass
  logic                           clr_active_r, clr_active_nxt;
  logic [scgqc_pkg::MAP_AW-1:0]   clr_addr_r, clr_addr_nxt;

  // item stage
  logic              s1_valid_r, s1_valid_nxt;
  scgqc_pkg::cmd_t   s1_cmd_r;
  logic              s1_in_range_r;
  logic              s1_has_res;
  logic              s1_adv;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r;
  scgqc_pkg::count_t out_trt_r;
  scgqc_pkg::count_t out_cntrl_r;
  logic              out_ok_r;
  scgqc_pkg::count_t out_total_r;
  scgqc_pkg::pairs_t out_pairs_r;

  // result payload built in the item stage
  logic              res_kind;
  scgqc_pkg::count_t res_trt;
  scgqc_pkg::count_t res_cntrl;
  logic              res_ok;
  scgqc_pkg::count_t res_total;

  logic              in_accept;
  logic              in_range;
  logic              s1_hit;
  scgqc_pkg::cmd_t   in_cmd_e;

  // bitmap RAM
  logic                           map_we;
  logic [scgqc_pkg::MAP_AW-1:0]   map_waddr;
  scgqc_pkg::epoch_t              map_wdata;
  logic [scgqc_pkg::MAP_AW-1:0]   map_addr;
  scgqc_pkg::epoch_t              map_rdata;

  assign in_cmd_e  = scgqc_pkg::cmd_t'(in_cmd);
  assign in_range  = scgqc_pkg::CMP_W'(in_cell_index) < scgqc_pkg::CMP_W'(scgqc_pkg::CELLS);
  assign map_addr  = scgqc_pkg::MAP_AW'(in_cell_index);

  assign s1_has_res = (s1_cmd_r == scgqc_pkg::CMD_END_NT) ||
                      ((s1_cmd_r == scgqc_pkg::CMD_END_PAIR) && pairs_en_r);
  assign s1_adv     = s1_valid_r && !(s1_has_res && out_valid_r && out_stall);
  assign in_stall   = clr_active_r || (s1_valid_r && !s1_adv);
  assign in_accept  = in_valid && !in_stall;
  assign s1_hit     = s1_in_range_r && (map_rdata == epoch_r);

  always_comb begin
    if (clr_active_r) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_r;
      map_wdata = '0;
    end else begin
      map_we    = in_accept && (in_cmd_e == scgqc_pkg::CMD_MARK) && in_range;
      map_waddr = map_addr;
      map_wdata = epoch_r;
    end
  end

  scgqc_ram #(
    .WIDTH (scgqc_pkg::EPOCH_W),
    .DEPTH (scgqc_pkg::CELLS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_accept),
    .raddr (map_addr),
    .rdata (map_rdata)
  );

  // tag bump on START; wrap starts a clearing pass
  always_comb begin
    epoch_nxt      = epoch_r;
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == scgqc_pkg::MAP_AW'(scgqc_pkg::CELLS - 1)) begin
        clr_active_nxt = 1'b0;
        clr_addr_nxt   = '0;
      end
    end else if (in_accept && (in_cmd_e == scgqc_pkg::CMD_START)) begin
      if (epoch_r == scgqc_pkg::EPOCH_MAX) begin
        epoch_nxt      = scgqc_pkg::EPOCH_FIRST;
        clr_active_nxt = 1'b1;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  // counter updates and result of the item in the item stage
  always_comb begin
    logic [scgqc_pkg::COUNT_W-1:0] cntrl;
    logic                          ok;
    group_hits_nxt  = group_hits_r;
    control_sum_nxt = control_sum_r;
    mark_count_nxt  = mark_count_r;
    pass_pairs_nxt  = pass_pairs_r;
    res_kind        = 1'b0;
    res_trt         = group_hits_r;
    res_cntrl       = '0;
    res_ok          = 1'b0;
    res_total       = compl_mode_r ? mark_count_r : control_sum_r;
    cntrl           = compl_mode_r
                      ? ((mark_count_r > group_hits_r) ? (mark_count_r - group_hits_r) : '0)
                      : control_sum_r;
    ok              = (cntrl >= cntrl_thr_r) && (group_hits_r >= trt_thr_r);
    if (s1_adv) begin
      case (s1_cmd_r)
        scgqc_pkg::CMD_START: begin
          group_hits_nxt  = '0;
          control_sum_nxt = '0;
          mark_count_nxt  = '0;
        end
        scgqc_pkg::CMD_MARK: begin
          mark_count_nxt = scgqc_pkg::count_add(mark_count_r, scgqc_pkg::COUNT_W'(1));
        end
        scgqc_pkg::CMD_MEMBER: begin
          if (s1_hit) begin
            group_hits_nxt = scgqc_pkg::count_add(group_hits_r, scgqc_pkg::COUNT_W'(1));
          end
        end
        scgqc_pkg::CMD_END_NT: begin
          control_sum_nxt = scgqc_pkg::count_add(control_sum_r, group_hits_r);
          group_hits_nxt  = '0;
          if (!compl_mode_r) begin
            res_total = control_sum_nxt;
          end
        end
        scgqc_pkg::CMD_END_PAIR: begin
          group_hits_nxt = '0;
          res_kind       = 1'b1;
          res_cntrl      = cntrl;
          res_ok         = ok;
          if (pairs_en_r && ok && (pass_pairs_r != scgqc_pkg::PAIRS_MAX)) begin
            pass_pairs_nxt = pass_pairs_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && s1_has_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trt_thr_r     <= '0;
      cntrl_thr_r   <= '0;
      compl_mode_r  <= 1'b0;
      pairs_en_r    <= 1'b1;
      group_hits_r  <= '0;
      control_sum_r <= '0;
      mark_count_r  <= '0;
      pass_pairs_r  <= '0;
      epoch_r       <= scgqc_pkg::EPOCH_FIRST;
      clr_active_r  <= 1'b1;
      clr_addr_r    <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (scgqc_pkg::cfg_reg_t'(cfg_index))
          scgqc_pkg::REG_TRT_THRESHOLD:   trt_thr_r    <= cfg_wdata;
          scgqc_pkg::REG_CNTRL_THRESHOLD: cntrl_thr_r  <= cfg_wdata;
          scgqc_pkg::REG_COMPLEMENT_MODE: compl_mode_r <= cfg_wdata[0];
          scgqc_pkg::REG_PAIRS_ENABLE:    pairs_en_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      group_hits_r  <= group_hits_nxt;
      control_sum_r <= control_sum_nxt;
      mark_count_r  <= mark_count_nxt;
      pass_pairs_r  <= pass_pairs_nxt;
      epoch_r       <= epoch_nxt;
      clr_active_r  <= clr_active_nxt;
      clr_addr_r    <= clr_addr_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r      <= in_cmd_e;
      s1_in_range_r <= in_range;
    end
    if (s1_adv && s1_has_res) begin
      out_kind_r  <= res_kind;
      out_trt_r   <= res_trt;
      out_cntrl_r <= res_cntrl;
      out_ok_r    <= res_ok;
      out_total_r <= res_total;
      out_pairs_r <= pass_pairs_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_trt_count      = out_trt_r;
  assign out_cntrl_count    = out_cntrl_r;
  assign out_pair_ok        = out_ok_r;
  assign out_column_total   = out_total_r;
  assign out_ok_pairs_total = out_pairs_r;

  `SCGQC_ASSERT_IMP(a_tag_nonzero, !clr_active_r, epoch_r != '0, "column tag is zero")
  `SCGQC_ASSERT_IMP(a_group_result_clean, out_valid_r && !out_kind_r,
                    (out_cntrl_r == '0) && !out_ok_r, "group result carries pair data")
  `SCGQC_ASSERT_NXT(a_item_held, s1_valid_r && s1_has_res && out_valid_r && out_stall,
                    s1_valid_r && $stable(s1_cmd_r), "blocked item left the item stage")
  `SCGQC_ASSERT_IMP(a_count_sat, 1'b1,
                    (group_hits_r <= scgqc_pkg::COUNT_MAX) &&
                    (control_sum_r <= scgqc_pkg::COUNT_MAX) &&
                    (mark_count_r <= scgqc_pkg::COUNT_MAX), "counter beyond saturation")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sparse column group QC counter core.
`timescale 1ns / 100ps

module testbench;
  import scgqc_pkg::*;

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam logic       KIND_GROUP       = 1'b0;
  localparam logic       KIND_PAIR        = 1'b1;
  localparam int         SETTLE_CYCLES    = 6;
  localparam int         LONG_HOLD        = 300;
  localparam int         TAIL_RUN         = 16;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [IDX_W-1:0] idx;
  } cmd_beat_t;

  typedef struct packed {
    logic   kind;
    count_t trt;
    count_t cntrl;
    logic   ok;
    count_t total;
    pairs_t pairs;
  } qc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       in_cmd = '0;
  logic [IDX_W-1:0] in_cell_index = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_kind;
  count_t           out_trt_count;
  count_t           out_cntrl_count;
  logic             out_pair_ok;
  count_t           out_column_total;
  pairs_t           out_ok_pairs_total;

  sparse_column_group_qc_counter_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_trt_count      (out_trt_count),
    .out_cntrl_count    (out_cntrl_count),
    .out_pair_ok        (out_pair_ok),
    .out_column_total   (out_column_total),
    .out_ok_pairs_total (out_ok_pairs_total)
  );

  // column state mirror
  bit     col_map [CELLS];
  count_t grp_hits = '0;
  count_t ctl_sum = '0;
  count_t marks = '0;
  pairs_t ok_pairs = '0;
  // register mirror
  count_t trt_min = '0;
  count_t ctl_min = '0;
  bit     complement_on = 1'b0;
  bit     pairs_on = 1'b1;

  cmd_beat_t  beat_queue[$];
  qc_result_t pending_results[$];

  int unsigned beats_queued = 0;
  int unsigned beats_sent = 0;
  int unsigned groups_seen = 0;
  int unsigned pairs_seen = 0;
  int unsigned passes_seen = 0;
  int unsigned mismatches = 0;

  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  bit quiet = 1'b0;
  bit hold_arm = 1'b0;

  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic count_t bump_count(count_t c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  // Advance the mirror by one accepted beat and queue the result it causes.
  task automatic apply_command(logic [2:0] cmd, logic [IDX_W-1:0] idx);
    qc_result_t       r;
    logic [COUNT_W:0] wide;
    r = '0;
    case (cmd)
      CMD_START: begin
        foreach (col_map[i]) col_map[i] = 1'b0;
        grp_hits = '0;
        ctl_sum = '0;
        marks = '0;
      end
      CMD_MARK: begin
        if (idx < CELLS) col_map[idx] = 1'b1;
        marks = bump_count(marks);
      end
      CMD_MEMBER: begin
        if (idx < CELLS && col_map[idx]) grp_hits = bump_count(grp_hits);
      end
      CMD_END_NT: begin
        r.kind = KIND_GROUP;
        r.trt = grp_hits;
        wide = {1'b0, ctl_sum} + {1'b0, grp_hits};
        ctl_sum = (wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : wide[COUNT_W-1:0];
        grp_hits = '0;
        r.total = complement_on ? marks : ctl_sum;
        r.pairs = ok_pairs;
        pending_results.push_back(r);
      end
      CMD_END_PAIR: begin
        r.kind = KIND_PAIR;
        r.trt = grp_hits;
        grp_hits = '0;
        if (pairs_on) begin
          if (complement_on) r.cntrl = (marks > r.trt) ? marks - r.trt : '0;
          else r.cntrl = ctl_sum;
          r.ok = (r.cntrl >= ctl_min) && (r.trt >= trt_min);
          if (r.ok && ok_pairs != PAIRS_MAX) ok_pairs = ok_pairs + 1'b1;
          r.total = complement_on ? marks : ctl_sum;
          r.pairs = ok_pairs;
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_cmd, in_cell_index);
        beats_sent++;
      end
      if (in_valid && in_stall) begin
        // stalled beat stays put
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        cmd_beat_t b;
        b = beat_queue.pop_front();
        in_cmd <= b.cmd;
        in_cell_index <= b.idx;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_arm && !hold_used) begin
      // one long hold so the pipe backs up into the input
      hold_used <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    qc_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_trt_count, out_cntrl_count, out_pair_ok,
              out_column_total, out_ok_pairs_total};
      if (got.kind == KIND_PAIR) pairs_seen++;
      else groups_seen++;
      if (got.kind == KIND_PAIR && got.ok) passes_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch @%0t: unexpected result kind=%0d trt=%0d cntrl=%0d ok=%0d",
                   $time, got.kind, got.trt, got.cntrl, got.ok);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch @%0t: expected kind=%0d trt=%0d cntrl=%0d ok=%0d total=%0d pairs=%0d",
                     $time, want.kind, want.trt, want.cntrl, want.ok, want.total, want.pairs);
            $display("             actual   kind=%0d trt=%0d cntrl=%0d ok=%0d total=%0d pairs=%0d",
                     got.kind, got.trt, got.cntrl, got.ok, got.total, got.pairs);
          end
        end
      end
    end
  end

  task automatic add_beat(logic [2:0] cmd, logic [IDX_W-1:0] idx);
    beat_queue.push_back(cmd_beat_t'{cmd, idx});
    if (cmd <= CMD_END_PAIR) beats_queued++;
  endtask

  function automatic logic [IDX_W-1:0] random_cell();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return IDX_W'(CELLS - 1);
      default: return IDX_W'($urandom_range(0, CELLS - 1));
    endcase
  endfunction

  function automatic count_t pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_MAX;
      2:       return count_t'($urandom_range(0, COUNT_MAX));
      default: return count_t'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic set_reg(cfg_reg_t which, count_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      REG_TRT_THRESHOLD:   trt_min = value;
      REG_CNTRL_THRESHOLD: ctl_min = value;
      REG_COMPLEMENT_MODE: complement_on = value[0];
      REG_PAIRS_ENABLE:    pairs_on = value[0];
      default: ;
    endcase
  endtask

  // Block until every queued beat is taken and every result is back,
  // then give the pipe time to finish beats that produce nothing.
  task automatic wait_idle();
    do @(negedge clk);
    while (beat_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Columns of marks, member tests and group closes, with a sprinkle of noise.
  task automatic queue_columns(int unsigned n_beats);
    logic [IDX_W-1:0] pool [12];
    int unsigned      n_pool, target;
    target = beats_queued + n_beats;
    while (beats_queued < target) begin
      if ($urandom_range(0, 9) != 0) add_beat(CMD_START, random_cell());
      n_pool = $urandom_range(1, 12);
      for (int i = 0; i < n_pool; i++) begin
        pool[i] = random_cell();
        add_beat(CMD_MARK, pool[i]);
        if ($urandom_range(0, 4) == 0) add_beat(CMD_MARK, pool[i]);
      end
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 3) != 0)
            add_beat(CMD_MEMBER, pool[$urandom_range(0, n_pool - 1)]);
          else
            add_beat(CMD_MEMBER, random_cell());
          if ($urandom_range(0, 19) == 0) add_beat(CMD_MARK, random_cell());
          if ($urandom_range(0, 24) == 0)
            add_beat(3'($urandom_range(0, CMD_UNUSED_LAST)), random_cell());
        end
        add_beat($urandom_range(0, 1) ? CMD_END_PAIR : CMD_END_NT, random_cell());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, repeats, misses, unused codes, empty groups
    add_beat(CMD_START, '0);
    add_beat(CMD_MARK, '0);
    add_beat(CMD_MARK, '1);
    add_beat(CMD_MARK, '0);
    add_beat(CMD_MEMBER, '0);
    add_beat(CMD_MEMBER, '1);
    add_beat(CMD_MEMBER, 12'd1);
    add_beat(CMD_END_NT, 12'hAAA);
    add_beat(CMD_MEMBER, '0);
    add_beat(CMD_END_PAIR, 12'h555);
    add_beat(CMD_UNUSED_FIRST, '1);
    add_beat(3'd6, '0);
    add_beat(CMD_UNUSED_LAST, 12'hAAA);
    add_beat(CMD_END_NT, '0);
    add_beat(CMD_END_PAIR, '0);
    wait_idle();

    // complement mode: treatment equal to the marks gives a control of zero
    set_reg(REG_COMPLEMENT_MODE, 13'd1);
    set_reg(REG_TRT_THRESHOLD, 13'd2);
    set_reg(REG_CNTRL_THRESHOLD, 13'd1);
    repeat (3) add_beat(CMD_MEMBER, '0);
    add_beat(CMD_END_PAIR, '0);
    add_beat(CMD_MEMBER, '1);
    add_beat(CMD_END_PAIR, '0);
    wait_idle();

    // pairs disabled: END_PAIR only drops the open group
    set_reg(REG_PAIRS_ENABLE, 13'd0);
    add_beat(CMD_MEMBER, '0);
    add_beat(CMD_END_PAIR, '0);
    add_beat(CMD_END_NT, '0);
    add_beat(CMD_START, '1);
    add_beat(CMD_END_NT, '0);
    wait_idle();

    // random columns under a range of register settings
    set_reg(REG_PAIRS_ENABLE, 13'd1);
    set_reg(REG_COMPLEMENT_MODE, 13'd0);
    set_reg(REG_TRT_THRESHOLD, pick_threshold());
    set_reg(REG_CNTRL_THRESHOLD, pick_threshold());
    queue_columns(200);
    wait_idle();

    set_reg(REG_COMPLEMENT_MODE, 13'd1);
    set_reg(REG_TRT_THRESHOLD, count_t'($urandom_range(0, 3)));
    set_reg(REG_CNTRL_THRESHOLD, count_t'($urandom_range(0, 3)));
    send_idle_pct <= 30;
    recv_idle_pct <= 30;
    repeat (40) add_beat(CMD_END_NT, random_cell());
    queue_columns(160);
    @(posedge clk);
    hold_arm <= 1'b1;
    wait_idle();

    set_reg(REG_PAIRS_ENABLE, 13'd0);
    set_reg(REG_COMPLEMENT_MODE, 13'($urandom_range(0, 1)));
    set_reg(REG_TRT_THRESHOLD, '0);
    set_reg(REG_CNTRL_THRESHOLD, '0);
    send_idle_pct <= 10;
    recv_idle_pct <= 10;
    queue_columns(200);
    wait_idle();

    set_reg(REG_PAIRS_ENABLE, 13'd1);
    set_reg(REG_TRT_THRESHOLD, COUNT_MAX);
    set_reg(REG_CNTRL_THRESHOLD, 13'd4095);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_columns(200);
    wait_idle();

    set_reg(REG_COMPLEMENT_MODE, 13'($urandom_range(0, 1)));
    set_reg(REG_TRT_THRESHOLD, pick_threshold());
    set_reg(REG_CNTRL_THRESHOLD, pick_threshold());
    send_idle_pct <= 20;
    recv_idle_pct <= 20;
    queue_columns(200);
    wait_idle();

    // tail with no idling: long groups and runs of pair closes, back to back
    quiet <= 1'b1;
    set_reg(REG_COMPLEMENT_MODE, 13'd1);
    set_reg(REG_TRT_THRESHOLD, '0);
    set_reg(REG_CNTRL_THRESHOLD, '0);
    add_beat(CMD_START, '0);
    add_beat(CMD_MARK, 12'd9);
    repeat (TAIL_RUN) add_beat(CMD_MARK, random_cell());
    add_beat(CMD_END_NT, '0);
    repeat (TAIL_RUN) add_beat(CMD_MEMBER, 12'd9);
    add_beat(CMD_END_PAIR, '0);
    wait_idle();

    set_reg(REG_COMPLEMENT_MODE, 13'd0);
    repeat (TAIL_RUN) add_beat(CMD_MEMBER, 12'd9);
    add_beat(CMD_END_NT, '0);
    repeat (3) add_beat(CMD_MEMBER, 12'd9);
    add_beat(CMD_END_NT, '0);
    repeat (TAIL_RUN) add_beat(CMD_END_PAIR, '0);
    add_beat(CMD_END_NT, '0);
    wait_idle();

    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("mismatch: %0d expected results never arrived", pending_results.size());
    end
    $display("summary: %0d beats taken, %0d group closes and %0d pair results checked",
             beats_sent, groups_seen, pairs_seen);
    $display("summary: %0d passing pairs seen, %0d mismatches", passes_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
